FILE: sv/segment_triangle_intersect_assert.svh
`ifndef SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sti_pkg.sv
package sti_pkg;

    localparam int NUM_REGS     = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QPTR_BITS    = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: sv/sti_front.sv
module sti_front
    import sti_pkg::*;
#(
    parameter int C  = 20,
    parameter int DW = 67
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [C-1:0]  vert [9],
    input  logic signed [C-1:0]  seg [6],
    input  logic                 pop,
    output logic                 push,
    output logic                 push_hit,
    output logic [DW-1:0]        push_t,
    output logic [DW-1:0]        push_d
);

    localparam int DFW = C + 1;
    localparam int NW  = 2 * C + 3;
    localparam int LB  = (NW + 1) / 2;
    localparam int HB  = NW - LB;
    localparam int PW  = DFW + NW;

    function automatic logic signed [NW-1:0] xm(
        input logic signed [DFW-1:0] u1,
        input logic signed [DFW-1:0] v2,
        input logic signed [DFW-1:0] u2,
        input logic signed [DFW-1:0] v1
    );
        logic signed [2*DFW-1:0] p1;
        logic signed [2*DFW-1:0] p2;
        p1 = u1 * v2;
        p2 = u2 * v1;
        return NW'(p1) - NW'(p2);
    endfunction

    logic [QPTR_BITS:0]       occ_reg;
    logic                     vld_reg [5];

    logic signed [DFW-1:0]    ab_reg [3];
    logic signed [DFW-1:0]    ac_reg [3];
    logic signed [DFW-1:0]    qp_reg [3];
    logic signed [DFW-1:0]    ap_reg [3];
    logic signed [DFW-1:0]    ab_next [3];
    logic signed [DFW-1:0]    ac_next [3];
    logic signed [DFW-1:0]    qp_next [3];
    logic signed [DFW-1:0]    ap_next [3];

    logic signed [DFW-1:0]    ab2_reg [3];
    logic signed [DFW-1:0]    ac2_reg [3];
    logic signed [DFW-1:0]    qp2_reg [3];
    logic signed [DFW-1:0]    ap2_reg [3];
    logic signed [NW-1:0]     n_reg [3];
    logic signed [NW-1:0]     e_reg [3];

    // dot order: d = qp.n, t = ap.n, v = ac.e, wn = ab.e
    logic signed [DFW+LB:0]   plo_reg [4][3];
    logic signed [DFW+HB-1:0] phi_reg [4][3];
    logic signed [DFW+LB:0]   plo_next [4][3];
    logic signed [DFW+HB-1:0] phi_next [4][3];
    logic signed [PW-1:0]     prod_reg [4][3];
    logic signed [DW-1:0]     sum_reg [4];

    logic signed [DW-1:0]     dv;
    logic signed [DW-1:0]     tv;
    logic signed [DW-1:0]     vv;
    logic signed [DW-1:0]     wv;
    logic signed [DW-1:0]     vw;
    logic                     hit;
    logic                     accept;

    assign in_ready = (occ_reg < (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (accept && !pop)
        begin
            occ_reg <= occ_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            occ_reg <= occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < 5; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab_next[i] = DFW'(vert[3+i]) - DFW'(vert[i]);
            ac_next[i] = DFW'(vert[6+i]) - DFW'(vert[i]);
            qp_next[i] = DFW'(seg[i]) - DFW'(seg[3+i]);
            ap_next[i] = DFW'(seg[i]) - DFW'(vert[i]);
        end
    end

    // Split each 43-bit style operand into an unsigned low half and signed high half.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            plo_next[0][i] = qp2_reg[i] * $signed({1'b0, n_reg[i][LB-1:0]});
            phi_next[0][i] = qp2_reg[i] * $signed(n_reg[i][NW-1:LB]);
            plo_next[1][i] = ap2_reg[i] * $signed({1'b0, n_reg[i][LB-1:0]});
            phi_next[1][i] = ap2_reg[i] * $signed(n_reg[i][NW-1:LB]);
            plo_next[2][i] = ac2_reg[i] * $signed({1'b0, e_reg[i][LB-1:0]});
            phi_next[2][i] = ac2_reg[i] * $signed(e_reg[i][NW-1:LB]);
            plo_next[3][i] = ab2_reg[i] * $signed({1'b0, e_reg[i][LB-1:0]});
            phi_next[3][i] = ab2_reg[i] * $signed(e_reg[i][NW-1:LB]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab_reg[i]  <= ab_next[i];
            ac_reg[i]  <= ac_next[i];
            qp_reg[i]  <= qp_next[i];
            ap_reg[i]  <= ap_next[i];
            ab2_reg[i] <= ab_reg[i];
            ac2_reg[i] <= ac_reg[i];
            qp2_reg[i] <= qp_reg[i];
            ap2_reg[i] <= ap_reg[i];
        end
        n_reg[0] <= xm(ab_reg[1], ac_reg[2], ab_reg[2], ac_reg[1]);
        n_reg[1] <= xm(ab_reg[2], ac_reg[0], ab_reg[0], ac_reg[2]);
        n_reg[2] <= xm(ab_reg[0], ac_reg[1], ab_reg[1], ac_reg[0]);
        e_reg[0] <= xm(qp_reg[1], ap_reg[2], qp_reg[2], ap_reg[1]);
        e_reg[1] <= xm(qp_reg[2], ap_reg[0], qp_reg[0], ap_reg[2]);
        e_reg[2] <= xm(qp_reg[0], ap_reg[1], qp_reg[1], ap_reg[0]);
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[k][i]  <= plo_next[k][i];
                phi_reg[k][i]  <= phi_next[k][i];
                prod_reg[k][i] <= (PW'(phi_reg[k][i]) <<< LB) + PW'(plo_reg[k][i]);
            end
            sum_reg[k] <= DW'(prod_reg[k][0]) + DW'(prod_reg[k][1]) + DW'(prod_reg[k][2]);
        end
    end

    always_comb
    begin
        dv  = sum_reg[0];
        tv  = sum_reg[1];
        vv  = sum_reg[2];
        wv  = -sum_reg[3];
        vw  = vv + wv;
        hit = (dv > 0) && (tv >= 0) && (tv <= dv) && (vv >= 0) && (vv <= dv)
              && (wv >= 0) && (vw <= dv);
    end

    // Misses divide 0 by 1 so the back end yields a zero fraction.
    assign push     = vld_reg[4];
    assign push_hit = hit;
    assign push_t   = hit ? tv : '0;
    assign push_d   = hit ? dv : DW'(1);

endmodule

FILE: sv/sti_queue.sv
module sti_queue
    import sti_pkg::*;
#(
    parameter int W = 135
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [W-1:0]  wr_data,
    input  logic          pop,
    output logic [W-1:0]  rd_data,
    output queue_status_t status
);

    logic [W-1:0]         mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/sti_back.sv
module sti_back
    import sti_pkg::*;
#(
    parameter int DW = 67,
    parameter int FB = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t status,
    input  logic          q_hit,
    input  logic [DW-1:0] q_t,
    input  logic [DW-1:0] q_d,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_hit,
    output logic [FB:0]   out_frac
);

    logic          vld_reg  [FB+1];
    logic          hit_reg  [FB+1];
    logic [FB:0]   q_reg    [FB+1];
    logic [DW-1:0] r_reg    [FB+1];
    logic [DW-1:0] d_reg    [FB+1];
    logic [FB:0]   q_next   [FB+1];
    logic [DW-1:0] r_next   [FB+1];
    logic [DW-1:0] rs       [FB+1];
    logic          en;

    // The whole divider advances together; hold it while the result waits.
    assign en  = !vld_reg[FB] || out_ready;
    assign pop = en && !status.empty;

    always_comb
    begin
        rs[0]     = q_t;
        q_next[0] = '0;
        r_next[0] = q_t;
        if (q_t >= q_d)
        begin
            r_next[0] = q_t - q_d;
            q_next[0] = (FB+1)'(1);
        end
        for (int k = 1; k <= FB; k++)
        begin
            rs[k]     = {r_reg[k-1][DW-2:0], 1'b0};
            q_next[k] = {q_reg[k-1][FB-1:0], 1'b0};
            r_next[k] = rs[k];
            if (rs[k] >= d_reg[k-1])
            begin
                r_next[k] = rs[k] - d_reg[k-1];
                q_next[k] = {q_reg[k-1][FB-1:0], 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FB; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !status.empty;
            for (int k = 1; k <= FB; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg[0] <= q_hit;
            d_reg[0]   <= q_d;
            r_reg[0]   <= r_next[0];
            q_reg[0]   <= q_next[0];
            for (int k = 1; k <= FB; k++)
            begin
                hit_reg[k] <= hit_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                r_reg[k]   <= r_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_valid = vld_reg[FB];
    assign out_hit   = hit_reg[FB];
    assign out_frac  = q_reg[FB];

endmodule

FILE: sv/segment_triangle_intersect.sv
// Channel   | Direction | Contents
// s_axis    | in        | tdata: vert_a_x,y,z, vert_b_x,y,z, vert_c_x,y,z (COORD_BITS each)
// m_axis    | out       | tdata: hit_fraction; tuser: hit
// cfg       | in        | cfg_index selects start_x..end_z, cfg_data is the value
//
// One triangle per cycle in and out while neither channel stalls. From the accepting edge
// to m_axis_tvalid a triangle passes five front stages (differences, cross products,
// split products, merge, dot sums), one queue write, and FRACTION_BITS + 1 restoring
// divide stages ending in the output.
// rst_n clears all control state and the segment registers to zero.
// s_axis_tready drops once eight triangles are in the front end or queue;
// a stalled output holds the divide pipeline, the front keeps filling the queue.
module segment_triangle_intersect
    import sti_pkg::*;
#(
    parameter int COORD_BITS    = 20,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, ..., vert_c_z from bit 0 up
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // hit_fraction from bit 0 up
    output logic [((FRACTION_BITS+8)/8)*8-1:0]        m_axis_tdata,
    // hit
    output logic [0:0]                                m_axis_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]                     cfg_data
);

    localparam int DW       = 3 * COORD_BITS + 7;
    localparam int OUT_W    = ((FRACTION_BITS + 8) / 8) * 8;
    localparam int QW       = 2 * DW + 1;
    localparam logic [FRACTION_BITS:0] FRAC_ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] start_z_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    logic signed [COORD_BITS-1:0] end_z_reg;
    logic signed [COORD_BITS-1:0] seg [6];
    logic signed [COORD_BITS-1:0] vert [9];

    logic                 push;
    logic                 push_hit;
    logic [DW-1:0]        push_t;
    logic [DW-1:0]        push_d;
    logic                 pop;
    logic [QW-1:0]        rd_data;
    queue_status_t        q_status;
    logic                 out_hit;
    logic [FRACTION_BITS:0] out_frac;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_START_Z: start_z_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_END_Z:   end_z_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        seg[0] = start_x_reg;
        seg[1] = start_y_reg;
        seg[2] = start_z_reg;
        seg[3] = end_x_reg;
        seg[4] = end_y_reg;
        seg[5] = end_z_reg;
        for (int i = 0; i < 9; i++)
        begin
            vert[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    sti_front #(
        .C  (COORD_BITS),
        .DW (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .vert     (vert),
        .seg      (seg),
        .pop      (pop),
        .push     (push),
        .push_hit (push_hit),
        .push_t   (push_t),
        .push_d   (push_d)
    );

    sti_queue #(
        .W (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_hit, push_t, push_d}),
        .pop     (pop),
        .rd_data (rd_data),
        .status  (q_status)
    );

    sti_back #(
        .DW (DW),
        .FB (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (q_status),
        .q_hit     (rd_data[QW-1]),
        .q_t       (rd_data[2*DW-1:DW]),
        .q_d       (rd_data[DW-1:0]),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hit   (out_hit),
        .out_frac  (out_frac)
    );

    assign m_axis_tdata    = OUT_W'(out_frac);
    assign m_axis_tuser[0] = out_hit;

`include "segment_triangle_intersect_assert.svh"

    `STI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], out_frac == '0, "miss with nonzero fraction")
    `STI_ASSERT_NOW(a_frac_range, m_axis_tvalid, out_frac <= FRAC_ONE, "fraction above one")
    `STI_ASSERT_NOW(a_no_overflow, push, !q_status.full || pop, "push into full queue")

endmodule
